/* sv/tdc_pkg.sv */
// Package: shared widths, constants and types of the turn-and-drive command generator.
`timescale 1ns / 1ps
package tdc_pkg;

	localparam int XW  = 43;  // CORDIC x/y width, signed
	localparam int ZW  = 24;  // CORDIC angle accumulator, Q16 degrees, signed
	localparam int SQW = 20;  // saturated radicand width
	localparam int RTW = 10;  // root width, whole cm
	localparam int ORW = 25;  // bearing / heading, Q16 degrees, unsigned
	localparam int DFW = 26;  // angle difference, signed

	// atan(2^-i) in Q16 degrees, rounded to nearest
	localparam logic signed [ZW-1:0] ATAN_Q16 [24] = '{
		24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
		24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
		24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
		24'sd917,     24'sd458,     24'sd229,    24'sd115,
		24'sd57,      24'sd29,      24'sd14,     24'sd7,
		24'sd4,       24'sd2,       24'sd1,      24'sd0
	};

	localparam logic [ORW-1:0] DEG90_Q16  = 25'd5898240;
	localparam logic [ORW-1:0] DEG180_Q16 = 25'd11796480;
	localparam logic [ORW-1:0] DEG270_Q16 = 25'd17694720;
	localparam logic [ORW-1:0] DEG360_Q16 = 25'd23592960;
	localparam logic [14:0]    HEADING_MAX = 15'd23040;

	localparam logic [1:0] KIND_LEFT  = 2'd0;
	localparam logic [1:0] KIND_RIGHT = 2'd1;
	localparam logic [1:0] KIND_RUN   = 2'd2;

	localparam logic CMD_DEFEND = 1'b1;

	localparam logic REG_MAX_RUN   = 1'b0;
	localparam logic REG_RUN_SPEED = 1'b1;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [SQW-1:0]       rem;
		logic [SQW-1:0]       root;
	} tdc_cordic_t;

endpackage

/* sv/tdc_in_if.sv */
// Interface: input transaction channel (robot pose, target, command).
`timescale 1ns / 1ps
interface tdc_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [3:0]         robot_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        heading;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;

	modport source (output valid, command, robot_id, pos_x, pos_y, heading,
		target_x, target_y, input ready);
	modport sink (input valid, command, robot_id, pos_x, pos_y, heading,
		target_x, target_y, output ready);
endinterface

/* sv/tdc_out_if.sv */
// Interface: action transaction channel.
`timescale 1ns / 1ps
interface tdc_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         action_robot;
	logic [1:0]         action_kind;
	logic [9:0]         magnitude;
	logic signed [8:0]  speed;
	logic signed [11:0] goal_x;
	logic signed [11:0] goal_y;
	logic               last;

	modport source (output valid, action_robot, action_kind, magnitude, speed,
		goal_x, goal_y, last, input ready);
	modport sink (input valid, action_robot, action_kind, magnitude, speed,
		goal_x, goal_y, last, output ready);
endinterface

/* sv/tdc_stage.sv */
// One pipeline stage: a CORDIC vectoring step plus, in some stages, two square-root steps.
`timescale 1ns / 1ps
module tdc_stage #(
	parameter int K = 0
) (
	input  logic                clk,
	input  logic                en,
	input  tdc_pkg::tdc_cordic_t d,
	output tdc_pkg::tdc_cordic_t q
);
	import tdc_pkg::*;

	localparam bit DO_SQRT = (K >= 2) && (K <= 6);
	localparam int J0      = DO_SQRT ? 2 * (K - 2) : 0;
	localparam int BIT0    = DO_SQRT ? (1 << (SQW - 2 - 2 * J0)) : 0;

	logic signed [XW-1:0] xs, ys, ny_mag;
	tdc_cordic_t          nq;
	logic [SQW-1:0]       s_v, r_v, b_v;
	logic [SQW:0]         t_v;

	always_comb begin
		xs     = d.x >>> K;
		ny_mag = -d.y;
		ys     = d.y[XW-1] ? -(ny_mag >>> K) : (d.y >>> K);
		nq     = d;
		if (!d.y[XW-1]) begin
			nq.x = d.x + ys;
			nq.y = d.y - xs;
			nq.z = d.z + ATAN_Q16[K];
		end else begin
			nq.x = d.x - ys;
			nq.y = d.y + xs;
			nq.z = d.z - ATAN_Q16[K];
		end

		// restoring square root, two result bits
		s_v = d.rem;
		r_v = d.root;
		for (int j = 0; j < 2; j++) begin
			b_v = SQW'(BIT0 >> (2 * j));
			t_v = {1'b0, r_v} + {1'b0, b_v};
			if ({1'b0, s_v} >= t_v) begin
				s_v = s_v - t_v[SQW-1:0];
				r_v = (r_v >> 1) + b_v;
			end else begin
				r_v = r_v >> 1;
			end
		end
		if (DO_SQRT) begin
			nq.rem  = s_v;
			nq.root = r_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nq;
		end
	end
endmodule

/* sv/turn_and_drive_command_gen_top.sv */
// Top level: turn-and-drive command generator pipeline and action sequencer.
`timescale 1ns / 1ps
// Each input transaction (robot pose, heading, target point, command) yields a
// turn toward the target, a forward run of the distance in whole cm capped by
// max_run_distance, and for defend a final turn back to 90 degrees. A defend
// target within 1 cm yields nothing. Inputs flow through a pipeline of
// ANGLE_ITERATIONS + 5 stages (capped at 24 iterations): difference, magnitude,
// one CORDIC vectoring step per stage with a square root worked two bits per
// stage alongside, then bearing, difference and fold stages. A sequencer at the
// end plays out the actions one per cycle while the action port is ready, so
// the block takes a new input transaction only once the last action of the
// previous one is taken; the single action port sets the input rate. Any stall
// on the action port freezes the whole pipeline, nothing is dropped or
// repeated. Configuration writes must be made while the block is empty.
module turn_and_drive_command_gen_top #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [9:0] cfg_wdata,
	tdc_in_if.sink     in_ch,
	tdc_out_if.source  out_ch
);
	import tdc_pkg::*;

	localparam int NI = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;

	localparam logic [1:0] IDX_TURN = 2'd0;
	localparam logic [1:0] IDX_RUN  = 2'd1;
	localparam logic [1:0] IDX_FACE = 2'd2;

	typedef struct packed {
		logic [3:0]         robot;
		logic               defend;
		logic [ORW-1:0]     head;
		logic signed [11:0] gx;
		logic signed [11:0] gy;
		logic               dx_neg;
		logic               dy_neg;
		logic               dx_zero;
		logic               dy_zero;
		logic               dy_pos;
		logic               near;
	} side_t;

	// shortest turn: {right, magnitude}
	function automatic logic [RTW:0] turn_fold(input logic signed [DFW-1:0] diff,
		input logic left);
		logic [DFW-1:0] mag_abs;
		logic [8:0]     deg;
		logic           l;
		mag_abs = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
		deg     = mag_abs[24:16];
		l       = left;
		if (deg > 9'd180) begin
			deg = 9'd360 - deg;
			l   = !l;
		end
		return {~l, 1'b0, deg};
	endfunction

	// configuration registers
	logic [9:0] max_run_q;
	logic [7:0] run_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_run_q   <= 10'd20;
			run_speed_q <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_RUN:   max_run_q   <= cfg_wdata;
				REG_RUN_SPEED: run_speed_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_last;

	// stage 1: differences, goal, heading clamp
	logic               v_s1;
	logic signed [16:0] dx_s1, dy_s1;
	side_t              side_s1;
	logic signed [16:0] tgx_r, tgy_r;
	logic [14:0]        hd_c;
	side_t              side_in;

	always_comb begin
		tgx_r = {in_ch.target_x[15], in_ch.target_x}
			+ (in_ch.target_x[15] ? 17'sd15 : 17'sd0);
		tgy_r = {in_ch.target_y[15], in_ch.target_y}
			+ (in_ch.target_y[15] ? 17'sd15 : 17'sd0);
		hd_c  = (in_ch.heading > HEADING_MAX) ? HEADING_MAX : in_ch.heading;
		side_in        = '0;
		side_in.robot  = in_ch.robot_id;
		side_in.defend = (in_ch.command == CMD_DEFEND);
		side_in.head   = {hd_c, 10'b0};
		side_in.gx     = tgx_r[15:4];
		side_in.gy     = tgy_r[15:4];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {in_ch.target_x[15], in_ch.target_x} - {in_ch.pos_x[15], in_ch.pos_x};
			dy_s1 <= {in_ch.target_y[15], in_ch.target_y} - {in_ch.pos_y[15], in_ch.pos_y};
			side_s1 <= side_in;
		end
	end

	// stage 2: magnitudes and quadrant flags
	logic               v_s2;
	logic [15:0]        ax_s2, ay_s2;
	side_t              side_s2;
	logic signed [16:0] ndx, ndy;
	side_t              side_flags;

	always_comb begin
		ndx = -dx_s1;
		ndy = -dy_s1;
		side_flags         = side_s1;
		side_flags.dx_neg  = dx_s1[16];
		side_flags.dy_neg  = dy_s1[16];
		side_flags.dx_zero = (dx_s1 == 17'sd0);
		side_flags.dy_zero = (dy_s1 == 17'sd0);
		side_flags.dy_pos  = !dy_s1[16] && (dy_s1 != 17'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= dx_s1[16] ? ndx[15:0] : dx_s1[15:0];
			ay_s2   <= dy_s1[16] ? ndy[15:0] : dy_s1[15:0];
			side_s2 <= side_flags;
		end
	end

	// CORDIC stages; squares ride along stage 0, root starts at stage 2
	tdc_cordic_t c_in, c1_in;
	tdc_cordic_t c_q [NI];
	side_t       side_c [NI];
	logic        vc [NI];
	logic [31:0] sqx_c0, sqy_c0;
	logic [32:0] sum_c;
	side_t       side_near;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_c0 <= ax_s2 * ax_s2;
			sqy_c0 <= ay_s2 * ay_s2;
		end
	end

	always_comb begin
		c_in      = '0;
		c_in.x    = {3'b0, ax_s2, 24'b0};
		c_in.y    = {3'b0, ay_s2, 24'b0};
		sum_c     = {1'b0, sqx_c0} + {1'b0, sqy_c0};
		c1_in     = c_q[0];
		// floor(sqrt(S)/16) == isqrt(S >> 8); above 20 bits the run is capped anyway
		c1_in.rem  = (sum_c[32:28] != 5'd0) ? {SQW{1'b1}} : sum_c[27:8];
		c1_in.root = '0;
		side_near      = side_c[0];
		side_near.near = (sum_c <= 33'd256);
	end

	for (genvar k = 0; k < NI; k++) begin : g_cordic
		tdc_cordic_t d_k;
		if (k == 0) begin : g_first
			assign d_k = c_in;
			always_ff @(posedge clk) begin
				if (en) side_c[k] <= side_s2;
			end
		end else if (k == 1) begin : g_second
			assign d_k = c1_in;
			always_ff @(posedge clk) begin
				if (en) side_c[k] <= side_near;
			end
		end else begin : g_rest
			assign d_k = c_q[k-1];
			always_ff @(posedge clk) begin
				if (en) side_c[k] <= side_c[k-1];
			end
		end
		tdc_stage #(.K(k)) u_stage (
			.clk (clk),
			.en  (en),
			.d   (d_k),
			.q   (c_q[k])
		);
	end

	// f1: clamp angle and place it in its quadrant
	logic                v_f1;
	logic [ORW-1:0]      orient_f1;
	logic [RTW-1:0]      root_f1;
	side_t               side_f1;
	logic signed [ZW-1:0] z_last;
	logic [ORW-1:0]      zc, orient_c;
	side_t               sd_last;

	always_comb begin
		z_last  = c_q[NI-1].z;
		sd_last = side_c[NI-1];
		if (z_last[ZW-1]) begin
			zc = '0;
		end else if ({1'b0, z_last} > DEG90_Q16) begin
			zc = DEG90_Q16;
		end else begin
			zc = {1'b0, z_last};
		end
		if (sd_last.dx_zero) begin
			orient_c = sd_last.dy_pos ? DEG90_Q16 : DEG270_Q16;
		end else if (sd_last.dy_zero) begin
			orient_c = sd_last.dx_neg ? DEG180_Q16 : '0;
		end else if (sd_last.dx_neg && sd_last.dy_neg) begin
			orient_c = DEG180_Q16 + zc;
		end else if (sd_last.dx_neg) begin
			orient_c = DEG180_Q16 - zc;
		end else if (sd_last.dy_neg) begin
			orient_c = DEG360_Q16 - zc;
		end else begin
			orient_c = zc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orient_f1 <= orient_c;
			root_f1   <= c_q[NI-1].root[RTW-1:0];
			side_f1   <= sd_last;
		end
	end

	// f2: angle differences, run cap
	logic                  v_f2;
	logic signed [DFW-1:0] diff1_f2, diff2_f2;
	logic                  left1_f2, left2_f2;
	logic [RTW-1:0]        dist_f2;
	side_t                 side_f2;

	always_ff @(posedge clk) begin
		if (en) begin
			diff1_f2 <= $signed({1'b0, orient_f1}) - $signed({1'b0, side_f1.head});
			diff2_f2 <= $signed({1'b0, orient_f1}) - $signed({1'b0, DEG90_Q16});
			left1_f2 <= orient_f1 > side_f1.head;
			left2_f2 <= orient_f1 < DEG90_Q16;
			dist_f2  <= (root_f1 > max_run_q) ? max_run_q : root_f1;
			side_f2  <= side_f1;
		end
	end

	// f3: shortest turns
	logic           v_f3;
	logic [RTW:0]   turn1_f3, turn2_f3;
	logic [RTW-1:0] dist_f3;
	side_t          side_f3;

	always_ff @(posedge clk) begin
		if (en) begin
			turn1_f3 <= turn_fold(diff1_f2, left1_f2);
			turn2_f3 <= turn_fold(diff2_f2, left2_f2);
			dist_f3  <= dist_f2;
			side_f3  <= side_f2;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < NI; k++) vc[k] <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
			v_f3 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_ch.valid;
			v_s2  <= v_s1;
			vc[0] <= v_s2;
			for (int k = 1; k < NI; k++) vc[k] <= vc[k-1];
			v_f1 <= vc[NI-1];
			v_f2 <= v_f1;
			v_f3 <= v_f2;
		end
	end

	// action sequencer: holds one input's results, one action per transaction
	logic           em_valid_q;
	logic [1:0]     em_idx_q;
	logic [RTW:0]   em_turn1_q, em_turn2_q;
	logic [RTW-1:0] em_dist_q;
	side_t          em_side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_idx_q   <= IDX_TURN;
		end else if (en) begin
			em_valid_q <= v_f3 && !(side_f3.defend && side_f3.near);
			em_idx_q   <= IDX_TURN;
		end else if (out_ch.ready) begin
			em_idx_q <= em_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			em_turn1_q <= turn1_f3;
			em_turn2_q <= turn2_f3;
			em_dist_q  <= dist_f3;
			em_side_q  <= side_f3;
		end
	end

	always_comb begin
		out_ch.valid        = em_valid_q;
		out_ch.action_robot = em_side_q.robot;
		out_ch.action_kind  = KIND_LEFT;
		out_ch.magnitude    = '0;
		out_ch.speed        = '0;
		out_ch.goal_x       = '0;
		out_ch.goal_y       = '0;
		out_ch.last         = 1'b1;
		case (em_idx_q)
			IDX_TURN: begin
				out_ch.action_kind = em_turn1_q[RTW] ? KIND_RIGHT : KIND_LEFT;
				out_ch.magnitude   = em_turn1_q[RTW-1:0];
				out_ch.last        = 1'b0;
			end
			IDX_RUN: begin
				out_ch.action_kind = KIND_RUN;
				out_ch.magnitude   = em_dist_q;
				out_ch.speed       = {1'b0, run_speed_q};
				out_ch.goal_x      = em_side_q.gx;
				out_ch.goal_y      = em_side_q.gy;
				out_ch.last        = !em_side_q.defend;
			end
			IDX_FACE: begin
				out_ch.action_kind = em_turn2_q[RTW] ? KIND_RIGHT : KIND_LEFT;
				out_ch.magnitude   = em_turn2_q[RTW-1:0];
				out_ch.speed       = -9'sd1;
			end
			default: ;
		endcase
		out_last    = out_ch.last;
		en          = !em_valid_q || (out_ch.ready && out_last);
		in_ch.ready = en;
	end

	// sequencer never walks past the defend turn
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> (em_idx_q == IDX_TURN || em_idx_q == IDX_RUN || em_idx_q == IDX_FACE))
		else $error("action index out of range");

	// a hold transaction ends at the run
	a_hold_two: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q && !em_side_q.defend |-> em_idx_q != IDX_FACE)
		else $error("hold item produced a third action");

	// runs respect the cap, turns are folded to the short way
	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.action_kind == KIND_RUN |-> out_ch.magnitude <= max_run_q)
		else $error("run longer than cap");

	a_turn_fold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.action_kind != KIND_RUN |-> out_ch.magnitude <= 10'd180)
		else $error("turn above 180 degrees");

	// a stalled action keeps its place in the sequence
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(em_idx_q))
		else $error("sequencer moved under stall");
endmodule

/* tb/turn_and_drive_command_gen_top_test.sv */
// Testbench: directed and randomized transaction-level check of the turn-and-drive command generator.
`timescale 1ns / 1ps
module turn_and_drive_command_gen_top_test;
	import tdc_pkg::*;

	localparam int ITERS      = 16;   // DUT default ANGLE_ITERATIONS, under the cap of 24
	localparam int DRAIN_WAIT = 60;   // pipeline depth is ITERS + 5 stages; allow margin
	localparam longint Q16    = 65536;

	localparam logic CMD_HOLD = 1'b0;

	typedef struct {
		logic               command;
		logic [3:0]         robot_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        heading;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} pose_t;

	typedef struct {
		logic [3:0]         robot;
		logic [1:0]         kind;
		logic [9:0]         magnitude;
		logic signed [8:0]  speed;
		logic signed [11:0] goal_x;
		logic signed [11:0] goal_y;
		logic               last;
	} action_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	logic       cfg_idx;
	logic [9:0] cfg_wdata;

	tdc_in_if  in_ch ();
	tdc_out_if out_ch ();

	turn_and_drive_command_gen_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the configuration registers
	logic [9:0] run_cap;
	logic [7:0] run_spd;

	pose_t   pose_queue [$];     // poses waiting to be driven
	action_t action_queue [$];   // actions predicted, not yet seen
	int      mismatches;
	bit      calm;               // when set, neither side idles

	// ---------------- predictor ----------------

	function automatic longint mag_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	// Bearing to the target in Q16 degrees
	function automatic longint bearing_q16(longint dx, longint dy);
		longint x, y, z, xs, ys;
		z = 0;
		if (dx == 0)
			return (dy > 0) ? 90 * Q16 : 270 * Q16;     // vertical ray, same point too
		if (dy == 0)
			return (dx > 0) ? 0 : 180 * Q16;            // horizontal ray
		x = ((dx < 0) ? -dx : dx) <<< 24;
		y = ((dy < 0) ? -dy : dy) <<< 24;
		for (int i = 0; i < ITERS; i++) begin
			xs = mag_shift(x, i);
			ys = mag_shift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(ATAN_Q16[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(ATAN_Q16[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > 90 * Q16) z = 90 * Q16;
		if (dx < 0 && dy < 0) return 180 * Q16 + z;
		if (dx < 0) return 180 * Q16 - z;
		if (dy < 0) return 360 * Q16 - z;
		return z;
	endfunction

	// Shortest turn: fold amounts above 180 and flip direction
	function automatic void shortest_turn(longint diff, bit left, output logic [1:0] kind,
			output logic [9:0] amount);
		longint deg;
		deg = ((diff < 0) ? -diff : diff) >>> 16;
		if (deg > 180) begin
			deg = 360 - deg;
			left = !left;
		end
		kind = left ? KIND_LEFT : KIND_RIGHT;
		amount = deg[9:0];
	endfunction

	function automatic longint root_floor(longint s);
		longint r, b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > s) b = b >>> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	task automatic predict_actions(input pose_t p);
		longint dx, dy, s, run_len, head, orient;
		action_t a;
		logic [1:0] k;
		logic [9:0] m;
		bit defend;
		defend = (p.command == CMD_DEFEND);
		dx = longint'(p.target_x) - longint'(p.pos_x);
		dy = longint'(p.target_y) - longint'(p.pos_y);
		s = dx * dx + dy * dy;
		run_len = root_floor(s) >>> 4;
		if (defend && s <= 256)
			return;                                     // defend within 1 cm: no actions
		head = (p.heading > HEADING_MAX) ? longint'(HEADING_MAX) : longint'(p.heading);
		head = head * 1024;
		orient = bearing_q16(dx, dy);
		shortest_turn(orient - head, orient > head, k, m);
		a = '{robot: p.robot_id, kind: k, magnitude: m, speed: 9'sd0,
			goal_x: 12'sd0, goal_y: 12'sd0, last: 1'b0};
		action_queue.insert(action_queue.size(), a);
		if (run_len > run_cap) run_len = run_cap;
		a.kind = KIND_RUN;
		a.magnitude = run_len[9:0];
		a.speed = {1'b0, run_spd};
		a.goal_x = 12'(p.target_x / 16);                // truncates toward zero
		a.goal_y = 12'(p.target_y / 16);
		a.last = !defend;
		action_queue.insert(action_queue.size(), a);
		if (defend) begin
			shortest_turn(orient - 90 * Q16, orient < 90 * Q16, k, m);
			a = '{robot: p.robot_id, kind: k, magnitude: m, speed: -9'sd1,
				goal_x: 12'sd0, goal_y: 12'sd0, last: 1'b1};
			action_queue.insert(action_queue.size(), a);
		end
	endtask

	// ---------------- driver ----------------
	// valid/payload are held while a pose waits on ready; otherwise each edge drives a new pose or drops valid.
	pose_t on_wire;
	always @(posedge clk) begin
		bit holding;
		if (arst_n) begin
			holding = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				predict_actions(on_wire);
				holding = 0;
			end
			if (!holding) begin
				if (pose_queue.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
					on_wire = pose_queue.pop_front();
					in_ch.command  <= on_wire.command;
					in_ch.robot_id <= on_wire.robot_id;
					in_ch.pos_x    <= on_wire.pos_x;
					in_ch.pos_y    <= on_wire.pos_y;
					in_ch.heading  <= on_wire.heading;
					in_ch.target_x <= on_wire.target_x;
					in_ch.target_y <= on_wire.target_y;
					in_ch.valid    <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		action_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (action_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected action: robot %0d kind %0d mag %0d",
							out_ch.action_robot, out_ch.action_kind, out_ch.magnitude);
				end else begin
					want = action_queue.pop_front();
					if (out_ch.action_robot !== want.robot || out_ch.action_kind !== want.kind
						|| out_ch.magnitude !== want.magnitude || out_ch.speed !== want.speed
						|| out_ch.goal_x !== want.goal_x || out_ch.goal_y !== want.goal_y
						|| out_ch.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"action mismatch: exp r%0d k%0d m%0d s%0d gx%0d gy%0d l%0d",
								" got r%0d k%0d m%0d s%0d gx%0d gy%0d l%0d"},
								want.robot, want.kind, want.magnitude, want.speed,
								want.goal_x, want.goal_y, want.last,
								out_ch.action_robot, out_ch.action_kind, out_ch.magnitude,
								out_ch.speed, out_ch.goal_x, out_ch.goal_y, out_ch.last);
					end
				end
			end
			out_ch.ready <= calm || $urandom_range(99) >= 19;
		end
	end

	// ---------------- stimulus ----------------

	task automatic add_pose(logic cmd, int id, int px, int py, int hd, int tx, int ty);
		pose_t p;
		p = '{command: cmd, robot_id: 4'(id), pos_x: 16'(px), pos_y: 16'(py),
			heading: 15'(hd), target_x: 16'(tx), target_y: 16'(ty)};
		pose_queue.insert(pose_queue.size(), p);
	endtask

	task automatic write_reg(logic idx, logic [9:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_MAX_RUN) run_cap = val;
		else run_spd = val[7:0];
	endtask

	// Block is idle once every transaction went in and every action came out;
	// defend transactions near the target leave no action, so wait out the pipe too.
	task automatic drain();
		while (pose_queue.size() > 0 || in_ch.valid || action_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic random_poses(int count);
		int px, py, tx, ty, hd, sel;
		for (int n = 0; n < count; n++) begin
			px = $urandom_range(65535) - 32768;
			py = $urandom_range(65535) - 32768;
			sel = $urandom_range(9);
			if (sel < 6) begin
				// nearby targets, so distances straddle the run cap
				tx = px + $urandom_range(1200) - 600;
				ty = py + $urandom_range(1200) - 600;
			end else if (sel == 6) begin
				// on an axis or almost on top of the robot
				tx = ($urandom_range(1)) ? px : px + $urandom_range(40) - 20;
				ty = ($urandom_range(1)) ? py : py + $urandom_range(40) - 20;
			end else begin
				tx = $urandom_range(65535) - 32768;
				ty = $urandom_range(65535) - 32768;
			end
			if (tx > 32767 || tx < -32768) tx = px - (tx - px);
			if (ty > 32767 || ty < -32768) ty = py - (ty - py);
			hd = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(23040);
			add_pose(1'($urandom_range(1)), int'($urandom_range(15)), px, py, hd, tx, ty);
		end
	endtask

	initial begin
		in_ch.valid    = 1'b0;
		in_ch.command  = CMD_HOLD;
		in_ch.robot_id = '0;
		in_ch.pos_x    = '0;
		in_ch.pos_y    = '0;
		in_ch.heading  = '0;
		in_ch.target_x = '0;
		in_ch.target_y = '0;
		out_ch.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_MAX_RUN;
		cfg_wdata      = '0;
		mismatches     = 0;
		calm           = 0;
		run_cap        = 10'd20;
		run_spd        = 8'd100;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed poses at reset configuration
		add_pose(CMD_HOLD,   0,  0, 0, 0, 160, 160);          // first quadrant
		add_pose(CMD_DEFEND, 15, 0, 0, 0, 0, 0);              // same point, defend: nothing
		add_pose(CMD_HOLD,   1,  0, 0, 23040, 0, 0);          // same point: bearing 270
		add_pose(CMD_HOLD,   2,  100, 100, 5760, 100, 900);   // vertical up
		add_pose(CMD_DEFEND, 3,  100, 100, 0, 100, -900);     // vertical down
		add_pose(CMD_HOLD,   4,  0, 0, 11520, 500, 0);        // horizontal right
		add_pose(CMD_DEFEND, 5,  0, 0, 0, -500, 0);           // horizontal left
		add_pose(CMD_DEFEND, 6,  0, 0, 0, 16, 0);             // exactly 1 cm: nothing
		add_pose(CMD_DEFEND, 7,  0, 0, 0, 17, 0);             // just beyond 1 cm
		add_pose(CMD_DEFEND, 8,  0, 0, 0, 11, 11);            // diagonal inside 1 cm
		add_pose(CMD_HOLD,   9,  -32768, -32768, 0, 32767, 32767);
		add_pose(CMD_DEFEND, 10, 32767, 32767, 23040, -32768, -32768);
		add_pose(CMD_HOLD,   11, 32767, -32768, 32767, -32768, 32767); // heading clamped
		add_pose(CMD_DEFEND, 12, 0, 0, 22000, 300, 40);       // fold above 180, final left
		add_pose(CMD_HOLD,   13, 0, 0, 1000, -300, -200);     // third quadrant, fold
		add_pose(CMD_DEFEND, 14, 0, 0, 16384, 300, -200);     // fourth quadrant
		add_pose(CMD_HOLD,   5,  0, 0, 0, -31, -31);          // negative goals truncate toward zero
		add_pose(CMD_DEFEND, 6,  -1000, 0, 12000, -1000, 1);  // tiny dy
		drain();

		// Extremes of both registers
		write_reg(REG_MAX_RUN, 10'd0);
		write_reg(REG_RUN_SPEED, 10'd0);
		random_poses(30);
		drain();
		write_reg(REG_MAX_RUN, 10'd1023);
		write_reg(REG_RUN_SPEED, 10'd255);
		calm = 1;                                             // back-to-back stretch
		random_poses(40);
		drain();
		calm = 0;
		write_reg(REG_MAX_RUN, 10'($urandom_range(1023)));
		write_reg(REG_RUN_SPEED, 10'($urandom_range(255)));
		random_poses(50);
		drain();
		write_reg(REG_MAX_RUN, 10'd20);
		write_reg(REG_RUN_SPEED, 10'd100);
		random_poses(40);
		drain();

		if (mismatches == 0 && action_queue.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
sv/tdc_pkg.sv
sv/tdc_in_if.sv
sv/tdc_out_if.sv
sv/tdc_stage.sv
sv/turn_and_drive_command_gen_top.sv
tb/turn_and_drive_command_gen_top_test.sv
